@@ rtl/lmph_pkg.sv @@
// ----------------------------------------------------------------------------
// lmph_pkg
// Shared types and constants for the level meter with peak hold.
// ----------------------------------------------------------------------------
package lmph_pkg;

  // Level format: unsigned fixed point, ONE means full scale
  localparam int unsigned LEVEL_FRAC_BITS = 15;
  localparam int unsigned LEVEL_W         = 16;
  localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1 << LEVEL_FRAC_BITS);

  // Segment count limits and field widths
  localparam int unsigned SEG_W    = 7;
  localparam logic [SEG_W-1:0] SEG_MIN = SEG_W'(5);
  localparam logic [SEG_W-1:0] SEG_MAX = SEG_W'(64);
  localparam int unsigned PSEG_W   = 6;
  localparam int unsigned FRAC_W   = 15;

  // Shared multiplier widths
  localparam int unsigned MUL_W  = 16;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // Gain is Q0.16
  localparam int unsigned GAIN_SHIFT = 16;

  // Configuration port
  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 32;

  typedef enum logic [1:0] {
    REG_SMOOTH_GAIN    = 2'd0,
    REG_DROP_STEP      = 2'd1,
    REG_SNAP_THRESHOLD = 2'd2,
    REG_SEGMENT_COUNT  = 2'd3
  } lmph_reg_t;

  localparam logic [15:0]      RST_SMOOTH_GAIN    = 16'd9830;
  localparam logic [15:0]      RST_DROP_STEP      = 16'd246;
  localparam logic [15:0]      RST_SNAP_THRESHOLD = 16'd33;
  localparam logic [SEG_W-1:0] RST_SEGMENT_COUNT  = SEG_W'(24);

  // Item kinds on the input channel
  localparam logic MODE_SET  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Register values as seen by the datapath
  typedef struct packed {
    logic [15:0]      smooth_gain;
    logic [15:0]      drop_step;
    logic [15:0]      snap_threshold;
    logic [SEG_W-1:0] segments;     // already clamped to the legal range
  } lmph_cfg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_STEP,
    ST_MOVE,
    ST_SEGL,
    ST_SEGP,
    ST_DONE
  } lmph_state_t;

endpackage

@@ rtl/lmph_mul.sv @@
// ----------------------------------------------------------------------------
// lmph_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module lmph_mul import lmph_pkg::*; (
  input  logic              clk,
  input  logic [MUL_W-1:0]  op_a,
  input  logic [MUL_W-1:0]  op_b,
  output logic [PROD_W-1:0] prod_r
);

  logic [PROD_W-1:0] prod_nxt;

  // Multiply; the product is registered and appears in the next cycle
  assign prod_nxt = PROD_W'(op_a) * PROD_W'(op_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

@@ rtl/lmph_regs.sv @@
// ----------------------------------------------------------------------------
// lmph_regs
// APB-style register file holding gain, decay, snap distance and segments.
// ----------------------------------------------------------------------------
module lmph_regs import lmph_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output lmph_cfg_t         cfg
);

  logic [15:0]      gain_r,  gain_nxt;
  logic [15:0]      decay_r, decay_nxt;
  logic [15:0]      snap_r,  snap_nxt;
  logic [SEG_W-1:0] segs_r,  segs_nxt;
  logic             wr_en;
  lmph_reg_t        sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = lmph_reg_t'(paddr[CFG_AW-1:2]);

  // Decode the write beat
  always_comb begin
    gain_nxt  = gain_r;
    decay_nxt = decay_r;
    snap_nxt  = snap_r;
    segs_nxt  = segs_r;
    if (wr_en) begin
      unique case (sel)
        REG_SMOOTH_GAIN:    gain_nxt  = pwdata[15:0];
        REG_DROP_STEP:      decay_nxt = pwdata[15:0];
        REG_SNAP_THRESHOLD: snap_nxt  = pwdata[15:0];
        REG_SEGMENT_COUNT:  segs_nxt  = pwdata[SEG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= RST_SMOOTH_GAIN;
      decay_r <= RST_DROP_STEP;
      snap_r  <= RST_SNAP_THRESHOLD;
      segs_r  <= RST_SEGMENT_COUNT;
    end else begin
      gain_r  <= gain_nxt;
      decay_r <= decay_nxt;
      snap_r  <= snap_nxt;
      segs_r  <= segs_nxt;
    end
  end

  // Read back
  always_comb begin
    unique case (sel)
      REG_SMOOTH_GAIN:    prdata = CFG_DW'(gain_r);
      REG_DROP_STEP:      prdata = CFG_DW'(decay_r);
      REG_SNAP_THRESHOLD: prdata = CFG_DW'(snap_r);
      REG_SEGMENT_COUNT:  prdata = CFG_DW'(segs_r);
      default:            prdata = '0;
    endcase
  end

  // Hand the datapath a segment count inside the legal range
  always_comb begin
    cfg.smooth_gain    = gain_r;
    cfg.drop_step      = decay_r;
    cfg.snap_threshold = snap_r;
    priority if (segs_r < SEG_MIN) begin
      cfg.segments = SEG_MIN;
    end else if (segs_r > SEG_MAX) begin
      cfg.segments = SEG_MAX;
    end else begin
      cfg.segments = segs_r;
    end
  end

endmodule

@@ rtl/level_meter_peak_hold_unit.sv @@
// ----------------------------------------------------------------------------
// level_meter_peak_hold_unit
// Bar-graph level meter: smoothed level, peak hold and segment decoding.
// ----------------------------------------------------------------------------
// One 16x16 multiplier with a registered product does all the arithmetic
// under a small sequencer, so items are handled one at a time. A set-target
// beat passes through LOAD, SEGL, SEGP and DONE before its result is loaded,
// and the next beat is taken once the sequencer is back in IDLE; a tick beat
// needs the smoothing product as well and adds STEP and MOVE after LOAD. The
// path is set by the products through the shared multiplier: the smoothing
// step on a tick, then the shown level and the peak times the segment count.
// A finished result waits in the output register; the unit accepts the next
// beat while it waits and only holds before loading a new result into it.
// Registers: 0x0 smooth gain (Q0.16), 0x4 peak decay, 0x8 snap threshold,
// 0xC segment count (values outside 5..64 act as the nearest limit).
// ----------------------------------------------------------------------------
module level_meter_peak_hold_unit import lmph_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Input beats
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] level
  input  logic [0:0]  in_tuser,    // [0] mode
  // Result beats
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // [15:0] shown_level, [31:16] peak_level,
                                   // [32] changed, [39:33] lit_segments,
                                   // [54:40] partial_fill, [60:55] peak_segment
  // Configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  lmph_cfg_t         cfg;
  lmph_state_t       state_r, state_nxt;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod_r;
  logic              out_free;

  logic              mode_r;
  logic [15:0]       level_r;
  logic [15:0]       target_r, disp_r, peak_r, mag_r;
  logic              up_r, snap_r, chg_r;
  logic [SEG_W-1:0]  lit_r;
  logic [FRAC_W-1:0] frac_r;

  logic [15:0]       clamp_lvl, step_val, disp_new, peak_dec, peak_new;
  logic [SEG_W-1:0]  lit_raw, pseg_raw, seg_last;
  logic [PSEG_W-1:0] pseg_val;

  logic              out_valid_r;
  logic [63:0]       out_data_r;

  lmph_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  lmph_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  assign out_free = !out_valid_r || out_tready;

  // Sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = (mode_r == MODE_TICK) ? ST_STEP : ST_SEGL;
      ST_STEP: state_nxt = ST_MOVE;
      ST_MOVE: state_nxt = ST_SEGL;
      ST_SEGL: state_nxt = ST_SEGP;
      ST_SEGP: state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer: ready and multiplier operands
  always_comb begin
    in_tready = 1'b0;
    mul_a     = peak_r;
    mul_b     = MUL_W'(cfg.segments);
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_STEP: begin
        mul_a = mag_r;
        mul_b = cfg.smooth_gain;
      end
      ST_SEGL: mul_a = disp_r;
      ST_LOAD, ST_MOVE, ST_SEGP, ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Clamp a new target to full scale
  assign clamp_lvl = (level_r > LEVEL_ONE) ? LEVEL_ONE : level_r;

  // Move the shown level, then let a peak above the target fall, but not below the shown level
  assign step_val = prod_r[GAIN_SHIFT +: 16];
  always_comb begin
    if (snap_r)    disp_new = target_r;
    else if (up_r) disp_new = disp_r + step_val;
    else           disp_new = disp_r - step_val;
    peak_dec = (peak_r >= cfg.drop_step) ? peak_r - cfg.drop_step : '0;
    if (peak_r > target_r) begin
      peak_new = (peak_dec < disp_new) ? disp_new : peak_dec;
    end else begin
      peak_new = peak_r;
    end
  end

  // Segment decoding from the products
  assign lit_raw  = prod_r[LEVEL_FRAC_BITS +: SEG_W];
  assign pseg_raw = prod_r[LEVEL_FRAC_BITS +: SEG_W];
  assign seg_last = cfg.segments - SEG_W'(1);
  assign pseg_val = (pseg_raw > seg_last) ? seg_last[PSEG_W-1:0] : pseg_raw[PSEG_W-1:0];

  // Level state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      disp_r   <= '0;
      peak_r   <= '0;
    end else begin
      if (state_r == ST_LOAD && mode_r == MODE_SET) begin
        target_r <= clamp_lvl;
        if (clamp_lvl > peak_r) peak_r <= clamp_lvl;
      end
      if (state_r == ST_MOVE) begin
        disp_r <= disp_new;
        peak_r <= peak_new;
      end
    end
  end

  // Per-item working registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      mode_r  <= in_tuser[0];
      level_r <= in_tdata;
    end
    if (state_r == ST_LOAD) begin
      up_r   <= (target_r >= disp_r);
      mag_r  <= (target_r >= disp_r) ? target_r - disp_r : disp_r - target_r;
      snap_r <= (((target_r >= disp_r) ? target_r - disp_r : disp_r - target_r)
                 <= cfg.snap_threshold);
      chg_r  <= 1'b0;
    end
    if (state_r == ST_MOVE) begin
      chg_r <= (disp_new != disp_r) || (peak_new != peak_r);
    end
    if (state_r == ST_SEGP) begin
      if (lit_raw >= cfg.segments) begin
        lit_r  <= cfg.segments;
        frac_r <= '0;
      end else begin
        lit_r  <= lit_raw;
        frac_r <= prod_r[FRAC_W-1:0];
      end
    end
  end

  // Output register: load when the previous result is gone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_data_r <= {3'b000, pseg_val, frac_r, lit_r, chg_r, peak_r, disp_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ rtl/lmph_checker.sv @@
// ----------------------------------------------------------------------------
// lmph_checker
// Port-level checks for the level meter, bound to the top level.
// ----------------------------------------------------------------------------
module lmph_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  // No result right after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // An accepted beat keeps the unit busy, so no new beat is taken while it is in work
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready ##1 !in_tready ##1 !in_tready)
    else $error("new beat taken while previous item still in work");

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed or dropped");

  // Shown and peak levels never exceed full scale
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:0] <= 16'd32768 && out_tdata[31:16] <= 16'd32768))
    else $error("level beyond full scale");

endmodule

bind level_meter_peak_hold_unit lmph_checker u_lmph_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ tb/level_meter_peak_hold_checker.sv @@
// ----------------------------------------------------------------------------
// level_meter_peak_hold_checker
// Passive scoreboard for the level meter: it tracks register writes and
// input beats, keeps its own copy of the meter state, predicts the bar for
// every accepted input beat and compares each result beat with the oldest
// prediction. It reports the number of mismatches and of predictions that
// are still waiting.
// ----------------------------------------------------------------------------
module level_meter_peak_hold_checker import lmph_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] level
  input  logic [0:0]  in_tuser,    // [0] mode
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,   // [15:0] shown_level, [31:16] peak_level,
                                   // [32] changed, [39:33] lit_segments,
                                   // [54:40] partial_fill, [60:55] peak_segment
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          outstanding,
  output int          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] shown;
    logic [15:0] peak;
    logic        changed;
    logic [6:0]  lit;
    logic [14:0] fill;
    logic [5:0]  pseg;
  } bar_t;

  // Register copy
  logic [15:0]      gain_q16;
  logic [15:0]      decay_step;
  logic [15:0]      snap_dist;
  logic [SEG_W-1:0] seg_setting;

  // Meter state
  logic [15:0] meter_target;
  logic [15:0] meter_shown;
  logic [15:0] meter_peak;

  bar_t bar_q[$];
  int   mismatches = 0;

  // Apply one input beat to the meter state and return the bar it shows
  function automatic bar_t advance_meter(input logic mode, input logic [15:0] lvl);
    logic [15:0] tgt;
    logic [15:0] old_shown;
    logic [15:0] old_peak;
    logic [63:0] diff;
    logic [63:0] step;
    logic [63:0] segs;
    logic [63:0] active;
    logic [63:0] lit;
    logic [63:0] fill;
    logic [63:0] pseg;
    bar_t        r;
    segs = (seg_setting < SEG_MIN) ? 64'(SEG_MIN) :
           (seg_setting > SEG_MAX) ? 64'(SEG_MAX) : 64'(seg_setting);
    r.changed = 1'b0;
    if (mode == MODE_SET) begin
      tgt = (lvl > LEVEL_ONE) ? LEVEL_ONE : lvl;
      meter_target = tgt;
      if (tgt > meter_peak) meter_peak = tgt;
    end else begin
      old_shown = meter_shown;
      old_peak  = meter_peak;
      diff = (meter_target >= meter_shown) ? 64'(meter_target - meter_shown)
                                           : 64'(meter_shown - meter_target);
      // Smooth toward the target, or snap when close enough
      if (diff > 64'(snap_dist)) begin
        step = (diff * 64'(gain_q16)) >> GAIN_SHIFT;
        if (meter_target >= meter_shown) meter_shown = meter_shown + step[15:0];
        else meter_shown = meter_shown - step[15:0];
      end else begin
        meter_shown = meter_target;
      end
      // Decay a peak held above the target, floored at the shown level
      if (meter_peak > meter_target) begin
        meter_peak = (meter_peak >= decay_step) ? meter_peak - decay_step : 16'd0;
        if (meter_peak < meter_shown) meter_peak = meter_shown;
      end
      r.changed = (meter_shown != old_shown) || (meter_peak != old_peak);
    end
    // Decode segments
    active = 64'(meter_shown) * segs;
    lit    = active >> LEVEL_FRAC_BITS;
    fill   = active & (64'(LEVEL_ONE) - 64'd1);
    if (lit >= segs) begin
      lit  = segs;
      fill = 64'd0;
    end
    pseg = (64'(meter_peak) * segs) >> LEVEL_FRAC_BITS;
    if (pseg > segs - 64'd1) pseg = segs - 64'd1;
    r.shown = meter_shown;
    r.peak  = meter_peak;
    r.lit   = lit[6:0];
    r.fill  = fill[14:0];
    r.pseg  = pseg[5:0];
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    bar_t want;
    bar_t got;
    if (!rst_n) begin
      gain_q16     = RST_SMOOTH_GAIN;
      decay_step   = RST_DROP_STEP;
      snap_dist    = RST_SNAP_THRESHOLD;
      seg_setting  = RST_SEGMENT_COUNT;
      meter_target = '0;
      meter_shown  = '0;
      meter_peak   = '0;
      bar_q.delete();
    end else begin
      // Check a result beat against the oldest prediction
      if (out_tvalid && out_tready) begin
        got.shown   = out_tdata[15:0];
        got.peak    = out_tdata[31:16];
        got.changed = out_tdata[32];
        got.lit     = out_tdata[39:33];
        got.fill    = out_tdata[54:40];
        got.pseg    = out_tdata[60:55];
        if (bar_q.size() == 0) begin
          $display("%0t ERROR result beat with nothing expected: shown=%0d peak=%0d",
                   $time, got.shown, got.peak);
          mismatches++;
        end else begin
          want = bar_q.pop_front();
          if (got !== want) begin
            $display("%0t ERROR expected shown=%0d peak=%0d chg=%0d lit=%0d fill=%0d pseg=%0d",
                     $time, want.shown, want.peak, want.changed, want.lit, want.fill,
                     want.pseg);
            $display("%0t ERROR actual   shown=%0d peak=%0d chg=%0d lit=%0d fill=%0d pseg=%0d",
                     $time, got.shown, got.peak, got.changed, got.lit, got.fill,
                     got.pseg);
            mismatches++;
          end
        end
      end
      // Track register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (lmph_reg_t'(cfg_paddr[3:2]))
          REG_SMOOTH_GAIN:    gain_q16    = cfg_pwdata[15:0];
          REG_DROP_STEP:      decay_step  = cfg_pwdata[15:0];
          REG_SNAP_THRESHOLD: snap_dist   = cfg_pwdata[15:0];
          REG_SEGMENT_COUNT:  seg_setting = cfg_pwdata[SEG_W-1:0];
          default: ;
        endcase
      end
      // Predict the bar for an accepted input beat
      if (in_tvalid && in_tready) bar_q.push_back(advance_meter(in_tuser[0], in_tdata));
    end
    outstanding <= bar_q.size();
    fail_count  <= mismatches;
  end

endmodule

@@ tb/level_meter_peak_hold_unit_test.sv @@
// ----------------------------------------------------------------------------
// level_meter_peak_hold_unit_test
// Top of the level meter testbench: drives set and tick beats, register
// writes and result back-pressure, and gives the verdict from the checker.
// A directed part covers clamping, snapping, full bar, peak decay past zero
// and the segment count limits; random phases then vary idling on both
// sides and the register settings, with one long result stall.
// ----------------------------------------------------------------------------
module level_meter_peak_hold_unit_test;
  import lmph_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS_PER_SETTING = 117;
  localparam int HOLD_CYCLES       = 400;
  localparam int QUIET_LIMIT       = 3000;
  localparam int TAIL_CYCLES       = 20;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata    = '0;
  logic [0:0]  in_tuser    = '0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [63:0] out_tdata;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int outstanding;
  int fail_count;
  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  int hold_token   = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int quiet        = 0;

  level_meter_peak_hold_unit u_top (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  level_meter_peak_hold_checker u_check (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .outstanding, .fail_count
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result back-pressure: random stalls, or a long hold when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_token != hold_seen) begin
      hold_seen  <= hold_token;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("%0t watchdog: no beat for %0d cycles, %0d results outstanding",
                 $time, quiet, outstanding);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // Offer one input beat after a random gap and hold it until accepted
  task automatic push_beat(input logic mode, input logic [15:0] lvl);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= lvl;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic push_random_beat();
    logic        mode;
    logic [15:0] lvl;
    mode = ($urandom_range(99) < 72) ? MODE_TICK : MODE_SET;
    case ($urandom_range(9))
      0: lvl = 16'($urandom);
      1: begin
        case ($urandom_range(3))
          0:       lvl = 16'd0;
          1:       lvl = LEVEL_ONE;
          2:       lvl = LEVEL_ONE - 16'd1;
          default: lvl = 16'hFFFF;
        endcase
      end
      default: lvl = 16'($urandom_range(0, 32768));
    endcase
    push_beat(mode, lvl);
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_write(input lmph_reg_t idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write all four registers; unused upper data bits carry noise
  task automatic apply_setting(input logic [15:0] gain, input logic [15:0] decay,
                               input logic [15:0] snap, input logic [6:0] segs);
    cfg_write(REG_SMOOTH_GAIN,    {16'($urandom), gain});
    cfg_write(REG_DROP_STEP,      {16'($urandom), decay});
    cfg_write(REG_SNAP_THRESHOLD, {16'($urandom), snap});
    cfg_write(REG_SEGMENT_COUNT,  {25'($urandom), segs});
  endtask

  task automatic apply_random_setting();
    logic [15:0] gain;
    logic [15:0] decay;
    logic [15:0] snap;
    case ($urandom_range(3))
      0:       gain = 16'd0;
      1:       gain = 16'hFFFF;
      default: gain = 16'($urandom);
    endcase
    case ($urandom_range(6))
      0:       decay = 16'd0;
      1:       decay = LEVEL_ONE;
      2:       decay = 16'hFFFF;
      default: decay = 16'($urandom_range(1, 600));
    endcase
    case ($urandom_range(7))
      0:       snap = 16'd0;
      1:       snap = LEVEL_ONE;
      2:       snap = 16'hFFFF;
      default: snap = 16'($urandom_range(0, 100));
    endcase
    apply_setting(gain, decay, snap, 7'($urandom_range(0, 127)));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: idle tick, clamping, level ignored on tick, peak hold
    push_beat(MODE_TICK, 16'd0);
    push_beat(MODE_SET,  16'hFFFF);
    push_beat(MODE_TICK, 16'hFFFF);
    push_beat(MODE_TICK, 16'd0);
    push_beat(MODE_SET,  LEVEL_ONE + 16'd1);
    push_beat(MODE_SET,  16'd16384);
    push_beat(MODE_TICK, 16'd0);
    push_beat(MODE_SET,  16'd0);
    push_beat(MODE_TICK, 16'd0);

    // Always snap, huge decay, segment count below the minimum: full bar,
    // peak falling past zero stops at the shown level, then a tick with no change
    wait_drain();
    apply_setting(16'd0, 16'hFFFF, LEVEL_ONE, 7'd0);
    push_beat(MODE_SET,  LEVEL_ONE);
    push_beat(MODE_TICK, 16'd0);
    push_beat(MODE_SET,  16'd100);
    push_beat(MODE_TICK, 16'd0);
    push_beat(MODE_TICK, 16'd0);

    // Full gain, no snap, no decay, segment count above the maximum
    wait_drain();
    apply_setting(16'hFFFF, 16'd0, 16'd0, 7'd127);
    push_beat(MODE_SET,  LEVEL_ONE - 16'd1);
    push_beat(MODE_TICK, 16'd0);
    push_beat(MODE_TICK, 16'd0);
    push_beat(MODE_SET,  16'd1);
    push_beat(MODE_TICK, 16'd0);

    // Zero gain with no snap: step computes to zero, only the peak moves
    wait_drain();
    apply_setting(16'd0, LEVEL_ONE, 16'd0, 7'd64);
    push_beat(MODE_SET,  16'd20000);
    push_beat(MODE_TICK, 16'd0);
    push_beat(MODE_TICK, 16'd0);
    wait_drain();
    cfg_write(REG_SEGMENT_COUNT, 32'd5);
    push_beat(MODE_SET,  LEVEL_ONE);
    push_beat(MODE_TICK, 16'd0);

    // Random phases: sender rarely idle, then receiver rarely idle, then neither
    for (int ph = 0; ph < 3; ph++) begin
      for (int k = 0; k < 3; k++) begin
        wait_drain();
        case (ph)
          0:       begin send_gap_pct = 7;  recv_gap_pct <= 75; end
          1:       begin send_gap_pct = 75; recv_gap_pct <= 7;  end
          default: begin send_gap_pct = 0;  recv_gap_pct <= 0;  end
        endcase
        apply_random_setting();
        // Long result stall while the sender keeps offering
        if (ph == 2 && k == 1) hold_token <= hold_token + 1;
        for (int n = 0; n < ITEMS_PER_SETTING; n++) push_random_beat();
      end
    end

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/lmph_pkg.sv
rtl/lmph_mul.sv
rtl/lmph_regs.sv
rtl/level_meter_peak_hold_unit.sv
rtl/lmph_checker.sv
tb/level_meter_peak_hold_checker.sv
tb/level_meter_peak_hold_unit_test.sv
